// ===== rtl/core/hrhs_pkg.sv =====
`default_nettype none

package hrhs_pkg;

   localparam int unsigned BYTE_W   = 8;
   localparam int unsigned STATUS_W = 10;
   localparam int unsigned LENGTH_W = 31;
   localparam int unsigned ACCUM_W  = 31;
   localparam int unsigned IDX_W    = 4;

   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_COLON = 8'h3A;

   localparam logic [IDX_W-1:0]    NAME_LEN   = 4'd14;
   localparam logic [STATUS_W-1:0] OK_STATUS  = 10'd200;
   localparam logic [34:0]         STATUS_MAX = 35'd999;
   localparam logic [34:0]         LENGTH_MAX = 35'h0_7FFF_FFFF;

   typedef enum logic [1:0] {
      OUT_OK         = 2'd0,
      OUT_NOLEN      = 2'd1,
      OUT_BAD_STATUS = 2'd2,
      OUT_READ_ERR   = 2'd3
   } outcome_type;

   typedef enum logic [7:0] {
      PH_NAME  = 8'b0000_0001,
      PH_SSKIP = 8'b0000_0010,
      PH_SDIG  = 8'b0000_0100,
      PH_SDONE = 8'b0000_1000,
      PH_VSKIP = 8'b0001_0000,
      PH_VDIG  = 8'b0010_0000,
      PH_VDONE = 8'b0100_0000,
      PH_OTHER = 8'b1000_0000
   } phase_type;

   typedef struct packed {
      phase_type          phase;
      logic [IDX_W-1:0]   idx;
      logic               mismatch;
      logic [ACCUM_W-1:0] accum;
   } line_state_type;

   typedef struct packed {
      logic                valid;
      outcome_type         outcome;
      logic [STATUS_W-1:0] status_code;
      logic [LENGTH_W-1:0] content_length;
   } result_type;

   // lower-case "content-length"
   function automatic logic [7:0] name_char(input logic [IDX_W-1:0] i);
      logic [7:0] c;
      case (i)
         4'd0:    c = "c";
         4'd1:    c = "o";
         4'd2:    c = "n";
         4'd3:    c = "t";
         4'd4:    c = "e";
         4'd5:    c = "n";
         4'd6:    c = "t";
         4'd7:    c = "-";
         4'd8:    c = "l";
         4'd9:    c = "e";
         4'd10:   c = "n";
         4'd11:   c = "g";
         4'd12:   c = "t";
         4'd13:   c = "h";
         default: c = 8'h00;
      endcase
      return c;
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= "0") && (c <= "9");
   endfunction

   function automatic logic is_blank(input logic [7:0] c);
      return (c == CHAR_SPACE) || ((c >= 8'h09) && (c <= 8'h0D));
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/hrhs_req_if.sv =====
`default_nettype none

interface hrhs_req_if;
   import hrhs_pkg::*;

   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] data_byte;
   logic              end_of_data;

   modport source (output valid, output data_byte, output end_of_data, input ready);
   modport sink   (input valid, input data_byte, input end_of_data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/hrhs_rsp_if.sv =====
`default_nettype none

interface hrhs_rsp_if;
   import hrhs_pkg::*;

   logic                valid;
   logic                ready;
   logic [1:0]          outcome;
   logic [STATUS_W-1:0] status_code;
   logic [LENGTH_W-1:0] content_length;

   modport source (output valid, output outcome, output status_code,
                   output content_length, input ready);
   modport sink   (input valid, input outcome, input status_code,
                   input content_length, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/hrhs_scan.sv =====
`default_nettype none

module hrhs_scan #(
   parameter int unsigned LINE_LIMIT = 1024
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       step,
   input  wire logic [hrhs_pkg::BYTE_W-1:0] data_byte,
   input  wire logic                       end_of_data,
   output hrhs_pkg::result_type            res
);
   import hrhs_pkg::*;

   localparam int unsigned CNT_W = $clog2(LINE_LIMIT + 1);

   line_state_type      line_ff, line_in;
   logic [7:0]          held_byte_ff, held_byte_in;
   logic                held_valid_ff, held_valid_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic [LENGTH_W-1:0] length_ff, length_in;

   line_state_type      line_ex;
   logic [CNT_W-1:0]    count_inc;
   logic                lone_cr;
   outcome_type         end_outcome;

   localparam line_state_type LINE_CLEAR = '{phase: PH_NAME, idx: '0, mismatch: 1'b0,
                                             accum: '0};

   function automatic logic [ACCUM_W-1:0] add_digit(input logic [ACCUM_W-1:0] acc,
                                                    input logic [7:0] c,
                                                    input logic for_length);
      logic [34:0] v;
      logic [34:0] lim;
      v   = ({4'b0, acc} << 3) + ({4'b0, acc} << 1) + {31'b0, c[3:0]};
      lim = for_length ? LENGTH_MAX : STATUS_MAX;
      return (v > lim) ? lim[ACCUM_W-1:0] : v[ACCUM_W-1:0];
   endfunction

   // scan one byte that is known not to be the last of its line
   function automatic line_state_type examine(input line_state_type s, input logic [7:0] c);
      line_state_type r;
      logic [7:0]     low;
      logic           name_part;
      r         = s;
      low       = ((c >= "A") && (c <= "Z")) ? c + 8'd32 : c;
      name_part = (s.phase == PH_NAME) || (s.phase == PH_SSKIP) ||
                  (s.phase == PH_SDIG) || (s.phase == PH_SDONE);
      if (name_part) begin
         if (c == CHAR_COLON) begin
            r.phase = (!s.mismatch && (s.idx == NAME_LEN)) ? PH_VSKIP : PH_OTHER;
            r.accum = '0;
         end else begin
            if (!s.mismatch) begin
               if ((s.idx < NAME_LEN) && (low == name_char(s.idx))) begin
                  r.idx = s.idx + 4'd1;
               end else begin
                  r.mismatch = 1'b1;
               end
            end
            unique case (s.phase)
               PH_NAME: begin
                  if (c == CHAR_SPACE) r.phase = PH_SSKIP;
               end
               PH_SSKIP: begin
                  if (is_digit(c)) begin
                     r.accum = add_digit('0, c, 1'b0);
                     r.phase = PH_SDIG;
                  end else if (c == CHAR_PLUS) begin
                     r.phase = PH_SDIG;
                  end else if (!is_blank(c)) begin
                     r.phase = PH_SDONE;
                  end
               end
               PH_SDIG: begin
                  if (is_digit(c)) r.accum = add_digit(s.accum, c, 1'b0);
                  else r.phase = PH_SDONE;
               end
               default: ;
            endcase
         end
      end else begin
         unique case (s.phase)
            PH_VSKIP: begin
               if (is_digit(c)) begin
                  r.accum = add_digit('0, c, 1'b1);
                  r.phase = PH_VDIG;
               end else if (c == CHAR_PLUS) begin
                  r.phase = PH_VDIG;
               end else if (!is_blank(c)) begin
                  r.phase = PH_VDONE;
               end
            end
            PH_VDIG: begin
               if (is_digit(c)) r.accum = add_digit(s.accum, c, 1'b1);
               else r.phase = PH_VDONE;
            end
            default: ;
         endcase
      end
      return r;
   endfunction

   assign line_ex   = held_valid_ff ? examine(line_ff, held_byte_ff) : line_ff;
   assign count_inc = count_ff + {{(CNT_W-1){1'b0}}, 1'b1};
   assign lone_cr   = (count_ff == {{(CNT_W-1){1'b0}}, 1'b1}) && (held_byte_ff == CHAR_CR);

   always_comb begin
      if (status_ff != OK_STATUS)   end_outcome = OUT_BAD_STATUS;
      else if (length_ff == '0)     end_outcome = OUT_NOLEN;
      else                          end_outcome = OUT_OK;
   end

   always_comb begin
      line_in        = line_ff;
      held_byte_in   = held_byte_ff;
      held_valid_in  = held_valid_ff;
      count_in       = count_ff;
      status_in      = status_ff;
      length_in      = length_ff;
      res.valid          = 1'b0;
      res.outcome        = OUT_READ_ERR;
      res.status_code    = status_ff;
      res.content_length = length_ff;

      if (step) begin
         if (end_of_data || (data_byte == CHAR_LF)) begin
            if (end_of_data || (count_ff == '0) || lone_cr) begin
               // header end or read error: report, then restart everything
               res.valid     = 1'b1;
               res.outcome   = lone_cr ? end_outcome : OUT_READ_ERR;
               line_in       = LINE_CLEAR;
               held_byte_in  = '0;
               held_valid_in = 1'b0;
               count_in      = '0;
               status_in     = '0;
               length_in     = '0;
            end else begin
               // held byte is the dropped line end
               if ((line_ff.phase == PH_NAME) || (line_ff.phase == PH_SSKIP) ||
                   (line_ff.phase == PH_SDIG) || (line_ff.phase == PH_SDONE)) begin
                  status_in = line_ff.accum[STATUS_W-1:0];
               end else if (line_ff.phase != PH_OTHER) begin
                  length_in = line_ff.accum[LENGTH_W-1:0];
               end
               line_in       = LINE_CLEAR;
               held_byte_in  = '0;
               held_valid_in = 1'b0;
               count_in      = '0;
            end
         end else if (count_inc >= CNT_W'(LINE_LIMIT)) begin
            // line split at the limit; the new byte is the dropped one
            if ((line_ex.phase == PH_NAME) || (line_ex.phase == PH_SSKIP) ||
                (line_ex.phase == PH_SDIG) || (line_ex.phase == PH_SDONE)) begin
               status_in = line_ex.accum[STATUS_W-1:0];
            end else if (line_ex.phase != PH_OTHER) begin
               length_in = line_ex.accum[LENGTH_W-1:0];
            end
            line_in       = LINE_CLEAR;
            held_byte_in  = '0;
            held_valid_in = 1'b0;
            count_in      = '0;
         end else begin
            line_in       = line_ex;
            held_byte_in  = data_byte;
            held_valid_in = 1'b1;
            count_in      = count_inc;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_ff       <= LINE_CLEAR;
         held_byte_ff  <= '0;
         held_valid_ff <= 1'b0;
         count_ff      <= '0;
         status_ff     <= '0;
         length_ff     <= '0;
      end else begin
         line_ff       <= line_in;
         held_byte_ff  <= held_byte_in;
         held_valid_ff <= held_valid_in;
         count_ff      <= count_in;
         status_ff     <= status_in;
         length_ff     <= length_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/http_response_header_scanner.sv =====
// HTTP response header scanner.
// req channel: one response byte per transaction (data_byte), or an end of
//   data marker (end_of_data = 1, data_byte ignored).
// rsp channel: one transaction per finished header or read error, carrying
//   outcome (ok, length unknown, bad status, read error), the last status
//   code and the last content-length seen.
// Throughput: one byte per cycle while no result waits on a low rsp.ready.
//   Each byte is held in an input register, scanned by combinational logic
//   (one compare chain and a multiply-add by ten), and any result lands in
//   the output register. A result becomes valid once the byte that ends the
//   header has left the input register and its result has been registered.
// Reset clears all scan state and the valid flags of both registers; the
//   block is ready as soon as reset is released. After each result the
//   scan restarts from a clean state.
// When rsp.ready is low a pending result holds; one more byte can still be
//   taken into the input register, and the input stalls after that until
//   the result is taken.
`default_nettype none

module http_response_header_scanner #(
   parameter int unsigned LINE_LIMIT = 1024
) (
   input  wire logic  clock,
   input  wire logic  reset,
   hrhs_req_if.sink   req,
   hrhs_rsp_if.source rsp
);
   import hrhs_pkg::*;

   logic                in_valid_ff, in_valid_in;
   logic [BYTE_W-1:0]   in_byte_ff;
   logic                in_eod_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [1:0]          rsp_outcome_ff;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic [LENGTH_W-1:0] rsp_length_ff;

   logic       out_free;
   logic       step;
   result_type res;

   assign out_free  = !rsp_valid_ff || rsp.ready;
   assign step      = in_valid_ff && out_free;
   assign req.ready = !in_valid_ff || out_free;

   assign in_valid_in  = req.valid || (in_valid_ff && !out_free);
   assign rsp_valid_in = step ? res.valid : (rsp_valid_ff && !rsp.ready);

   hrhs_scan #(
      .LINE_LIMIT (LINE_LIMIT)
   ) u_scan (
      .clock       (clock),
      .reset       (reset),
      .step        (step),
      .data_byte   (in_byte_ff),
      .end_of_data (in_eod_ff),
      .res         (res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         in_byte_ff <= req.data_byte;
         in_eod_ff  <= req.end_of_data;
      end
      if (step && res.valid) begin
         rsp_outcome_ff <= res.outcome;
         rsp_status_ff  <= res.status_code;
         rsp_length_ff  <= res.content_length;
      end
   end

   assign rsp.valid          = rsp_valid_ff;
   assign rsp.outcome        = rsp_outcome_ff;
   assign rsp.status_code    = rsp_status_ff;
   assign rsp.content_length = rsp_length_ff;

endmodule

`default_nettype wire

// ===== sim/http_response_header_scanner_tb.sv =====
module http_response_header_scanner_tb;
   import hrhs_pkg::*;

   localparam int LINE_MAX       = 1024;
   localparam int RANDOM_BYTES   = 150;
   localparam int RANDOM_HEADERS = 2;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int TAIL_CYCLES    = 8;
   localparam int LONG_HOLD      = 200;

   localparam logic [ACCUM_W-1:0] STATUS_SAT = 31'd999;
   localparam logic [ACCUM_W-1:0] LENGTH_SAT = 31'h7FFF_FFFF;
   localparam string NAME_TEXT = "content-length";

   typedef struct {
      outcome_type         outcome;
      logic [STATUS_W-1:0] status_code;
      logic [LENGTH_W-1:0] content_length;
   } header_result_type;

   logic clock;
   logic reset = 1'b1;

   hrhs_req_if req_ch ();
   hrhs_rsp_if rsp_ch ();

   http_response_header_scanner #(.LINE_LIMIT(LINE_MAX)) i_dut (
      .clock(clock),
      .reset(reset),
      .req  (req_ch),
      .rsp  (rsp_ch)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // scanner state as the block should hold it
   logic [7:0]          held_char;
   bit                  held_ok;
   int                  line_len;
   phase_type           scan_phase;
   int                  name_pos;
   bit                  name_off;
   logic [ACCUM_W-1:0]  num_acc;
   logic [STATUS_W-1:0] last_status;
   logic [LENGTH_W-1:0] last_length;

   header_result_type pending_headers[$];
   int                headers_predicted = 0;
   int                bytes_sent = 0;
   int                mismatches = 0;
   int                idle_cycles = 0;

   bit req_idle_on = 1'b1;
   bit rsp_idle_on = 1'b1;
   int rsp_hold_cycles = 0;

   function automatic bit digit_char(input logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic bit blank_char(input logic [7:0] c);
      return c == CHAR_SPACE || (c >= 8'h09 && c <= 8'h0D);
   endfunction

   function automatic logic [ACCUM_W-1:0] times_ten_plus(input logic [ACCUM_W-1:0] acc,
                                                         input logic [7:0] c,
                                                         input logic [ACCUM_W-1:0] cap);
      longint unsigned v;
      v = 64'(acc) * 64'd10 + 64'(c - "0");
      return (v > 64'(cap)) ? cap : v[ACCUM_W-1:0];
   endfunction

   function automatic void clear_line();
      held_char  = '0;
      held_ok    = 1'b0;
      line_len   = 0;
      scan_phase = PH_NAME;
      name_pos   = 0;
      name_off   = 1'b0;
      num_acc    = '0;
   endfunction

   function automatic void restart_scan();
      clear_line();
      last_status = '0;
      last_length = '0;
   endfunction

   // one byte known not to be the dropped last byte of its line
   function automatic void scan_char(input logic [7:0] c);
      logic [7:0] low;
      if (scan_phase inside {PH_NAME, PH_SSKIP, PH_SDIG, PH_SDONE}) begin
         if (c == CHAR_COLON) begin
            scan_phase = (!name_off && name_pos == NAME_LEN) ? PH_VSKIP : PH_OTHER;
            num_acc = '0;
            return;
         end
         low = (c >= "A" && c <= "Z") ? c + 8'd32 : c;
         if (!name_off) begin
            if (name_pos < NAME_LEN && low == NAME_TEXT[name_pos]) name_pos++;
            else name_off = 1'b1;
         end
         case (scan_phase)
            PH_NAME: begin
               if (c == CHAR_SPACE) scan_phase = PH_SSKIP;
            end
            PH_SSKIP: begin
               if (digit_char(c)) begin
                  num_acc = times_ten_plus('0, c, STATUS_SAT);
                  scan_phase = PH_SDIG;
               end else if (c == CHAR_PLUS) scan_phase = PH_SDIG;
               else if (!blank_char(c)) scan_phase = PH_SDONE;
            end
            PH_SDIG: begin
               if (digit_char(c)) num_acc = times_ten_plus(num_acc, c, STATUS_SAT);
               else scan_phase = PH_SDONE;
            end
            default: ;
         endcase
      end else begin
         case (scan_phase)
            PH_VSKIP: begin
               if (digit_char(c)) begin
                  num_acc = times_ten_plus('0, c, LENGTH_SAT);
                  scan_phase = PH_VDIG;
               end else if (c == CHAR_PLUS) scan_phase = PH_VDIG;
               else if (!blank_char(c)) scan_phase = PH_VDONE;
            end
            PH_VDIG: begin
               if (digit_char(c)) num_acc = times_ten_plus(num_acc, c, LENGTH_SAT);
               else scan_phase = PH_VDONE;
            end
            default: ;
         endcase
      end
   endfunction

   function automatic void commit_line();
      if (scan_phase inside {PH_NAME, PH_SSKIP, PH_SDIG, PH_SDONE})
         last_status = num_acc[STATUS_W-1:0];
      else if (scan_phase != PH_OTHER)
         last_length = num_acc;
      clear_line();
   endfunction

   function automatic void expect_header(input outcome_type o);
      pending_headers.push_back('{o, last_status, last_length});
      headers_predicted++;
      restart_scan();
   endfunction

   function automatic void header_done();
      if (last_status != OK_STATUS) expect_header(OUT_BAD_STATUS);
      else if (last_length == '0) expect_header(OUT_NOLEN);
      else expect_header(OUT_OK);
   endfunction

   function automatic bit lone_cr();
      return line_len == 1 && held_char == CHAR_CR;
   endfunction

   function automatic void scan_byte(input logic [7:0] b, input bit eod);
      if (eod) begin
         if (lone_cr()) header_done();
         else expect_header(OUT_READ_ERR);
         return;
      end
      if (b == CHAR_LF) begin
         if (line_len == 0) expect_header(OUT_READ_ERR);
         else if (lone_cr()) header_done();
         else commit_line();
         return;
      end
      if (held_ok) scan_char(held_char);
      held_char = b;
      held_ok   = 1'b1;
      line_len++;
      if (line_len >= LINE_MAX) begin
         if (lone_cr()) header_done();
         else commit_line();
      end
   endfunction

   task automatic report_mismatch(input string msg);
      $display("ERROR @%0t: %s", $time, msg);
      mismatches++;
   endtask

   // result side: compare each transaction with the oldest expectation
   always @(posedge clock) begin : check_results
      header_result_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_headers.size() == 0) begin
            report_mismatch($sformatf("unexpected result outcome=%0d status=%0d length=%0d",
                                      rsp_ch.outcome, rsp_ch.status_code,
                                      rsp_ch.content_length));
         end else begin
            want = pending_headers.pop_front();
            if (rsp_ch.outcome != want.outcome)
               report_mismatch($sformatf("outcome got %0d expected %0d",
                                         rsp_ch.outcome, want.outcome));
            if (rsp_ch.status_code != want.status_code)
               report_mismatch($sformatf("status_code got %0d expected %0d",
                                         rsp_ch.status_code, want.status_code));
            if (rsp_ch.content_length != want.content_length)
               report_mismatch($sformatf("content_length got %0d expected %0d",
                                         rsp_ch.content_length, want.content_length));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("timeout: no transaction for %0d cycles", idle_cycles);
         $display("FAILED: results differ");
         $finish;
      end
   end

   // result receiver: random stalls, and a long hold-off when one is requested
   initial begin : rsp_drive
      int n;
      rsp_ch.ready = 1'b0;
      wait (reset === 1'b0);
      @(negedge clock);
      forever begin
         n = rsp_idle_on ? $urandom_range(0, 12) : 0;
         if (rsp_hold_cycles > 0) begin
            n = rsp_hold_cycles;
            rsp_hold_cycles = 0;
         end
         if (n > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (n) @(negedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
         @(negedge clock);
      end
   end

   task automatic send_byte(input logic [7:0] b, input bit eod);
      int gap;
      gap = req_idle_on ? $urandom_range(0, 12) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.data_byte   <= b;
      req_ch.end_of_data <= eod;
      do @(posedge clock); while (!req_ch.ready);
      scan_byte(b, eod);
      bytes_sent++;
   endtask

   task automatic send_eod();
      send_byte(8'($urandom_range(0, 255)), 1'b1);
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_byte(s[i], 1'b0);
   endtask

   task automatic send_line(input string s, input bit with_cr = 1'b1);
      send_text(s);
      if (with_cr) send_byte(CHAR_CR, 1'b0);
      send_byte(CHAR_LF, 1'b0);
   endtask

   task automatic send_fill(input logic [7:0] c, input int n);
      repeat (n) send_byte(c, 1'b0);
   endtask

   task automatic wait_results();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (pending_headers.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
   endtask

   task automatic test_plain_headers();
      send_line("HTTP/1.1 200 OK");
      send_line("Content-Length: 1234");
      send_line("");
      send_line("HTTP/1.1 200 OK");
      send_line("");
      send_line("HTTP/1.1 404 Not Found");
      send_line("Content-Length: 10");
      send_line("");
      // no space: status becomes 0
      send_line("HTTP/1.1");
      send_line("");
      wait_results();
   endtask

   task automatic test_number_parsing();
      send_line("HTTP/1.1 \t +200 OK");
      send_line("CONTENT-LENGTH: \t+42");
      send_line("");
      send_line("HTTP/1.1 -200");
      send_line("content-length: -5");
      send_line("");
      send_line("HTTP/1.1 2000000");
      send_line("Content-Length: 99999999999");
      send_line("");
      // later lines win
      send_line("HTTP/1.1 500");
      send_line("Content-Length: 3");
      send_line("HTTP/1.1 200", 1'b0);
      send_line("cOnTeNt-LeNgTh: 77");
      send_line("");
      wait_results();
   endtask

   task automatic test_odd_lines();
      send_line("HTTP/1.1 200");
      send_line("Content-Lengthy: 5");
      send_line("Content-Lengt: 6");
      send_line("Content-Length : 8");
      send_text("X");
      send_byte(8'hFF, 1'b0);
      send_byte(8'h00, 1'b0);
      send_line(": 9");
      send_line("");
      wait_results();
   endtask

   task automatic test_read_errors();
      send_byte(CHAR_LF, 1'b0);
      send_line("HTTP/1.1 200 OK");
      send_line("", 1'b0);
      send_eod();
      send_text("HTTP/1.1 200");
      send_eod();
      send_line("HTTP/1.1 200 OK");
      send_line("Content-Length: 9");
      send_byte(CHAR_CR, 1'b0);
      send_eod();
      // two CRs are a line, not a header end
      send_line("HTTP/1.1 200");
      send_byte(CHAR_CR, 1'b0);
      send_line("");
      send_eod();
      wait_results();
   endtask

   task automatic test_long_lines();
      // the byte that fills the line is dropped and the rest starts a new line
      send_text("H 200");
      send_fill("a", LINE_MAX - 5);
      send_line("Content-Length: 5");
      send_line("");
      wait_results();
   endtask

   task automatic test_output_stall();
      req_idle_on = 1'b0;
      rsp_idle_on = 1'b0;
      rsp_hold_cycles = LONG_HOLD;
      repeat (3) begin
         send_line("HTTP/1.1 200");
         send_line("Content-Length: 1");
         send_line("");
         send_line("");
      end
      wait_results();
      req_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
   endtask

   function automatic string mix_case(input string s);
      string r;
      r = s;
      for (int i = 0; i < r.len(); i++)
         if (r[i] >= "a" && r[i] <= "z" && $urandom_range(0, 1)) r[i] = r[i] - 8'd32;
      return r;
   endfunction

   function automatic string status_text();
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4: return "200";
         5: return $sformatf("%0d", $urandom_range(100, 599));
         6: return "\t +200";
         7: return $sformatf("-%0d", $urandom_range(0, 999));
         8: return $sformatf("%0d", $urandom_range(1000, 99999999));
         default: return "";
      endcase
   endfunction

   function automatic string length_text();
      int unsigned big;
      big = $urandom();
      case ($urandom_range(0, 7))
         0, 1, 2: return $sformatf("%0d", $urandom_range(1, 99999));
         3: return $sformatf("%0d", big);
         4: return "0";
         5: return "  +99999999999";
         6: return $sformatf("-%0d", $urandom_range(1, 500));
         default: return $sformatf("\t%0dxyz", $urandom_range(0, 9999));
      endcase
   endfunction

   function automatic string other_header();
      case ($urandom_range(0, 5))
         0: return "Server: tb";
         1: return "Content-Type: text/plain";
         2: return mix_case("content-lengthx: 12");
         3: return "Content-Lengt: 4";
         4: return $sformatf("X-Seq: %0d", $urandom_range(0, 999));
         default: return "Transfer Encoding: chunked";
      endcase
   endfunction

   task automatic send_random_header();
      int extra;
      int len_pos;
      bit with_len;
      extra    = $urandom_range(0, 2);
      len_pos  = $urandom_range(0, extra);
      with_len = $urandom_range(0, 3) != 0;
      if ($urandom_range(0, 9) != 0)
         send_line($sformatf("HTTP/1.%0d %s%s", $urandom_range(0, 1), status_text(),
                             $urandom_range(0, 1) ? " OK" : ""),
                   $urandom_range(0, 9) != 0);
      for (int i = 0; i <= extra; i++) begin
         if (with_len && i == len_pos)
            send_line({mix_case("content-length"), ":", ($urandom_range(0, 3) ? " " : ""),
                       length_text()}, $urandom_range(0, 9) != 0);
         if (i < extra) send_line(other_header(), $urandom_range(0, 9) != 0);
      end
      case ($urandom_range(0, 19))
         0: send_byte(CHAR_LF, 1'b0);
         1: begin
            send_byte(CHAR_CR, 1'b0);
            send_eod();
         end
         2: send_eod();
         default: send_line("");
      endcase
   endtask

   task automatic send_random_noise();
      int n;
      n = $urandom_range(1, 24);
      repeat (n) begin
         case ($urandom_range(0, 7))
            0: send_byte(CHAR_CR, 1'b0);
            1: send_byte(CHAR_LF, 1'b0);
            default: send_byte(8'($urandom_range(0, 255)), 1'b0);
         endcase
      end
      if ($urandom_range(0, 2) == 0) send_eod();
   endtask

   task automatic test_random_traffic();
      int start_bytes;
      int start_results;
      int mode;
      start_bytes   = bytes_sent;
      start_results = headers_predicted;
      while (bytes_sent - start_bytes < RANDOM_BYTES ||
             headers_predicted - start_results < RANDOM_HEADERS) begin
         mode = $urandom_range(0, 3);
         req_idle_on = mode[0];
         rsp_idle_on = mode[1];
         if ($urandom_range(0, 4) != 0) send_random_header();
         else send_random_noise();
      end
      send_eod();
      wait_results();
   endtask

   initial begin
      req_ch.valid       = 1'b0;
      req_ch.data_byte   = '0;
      req_ch.end_of_data = 1'b0;
      restart_scan();
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_plain_headers();
      test_number_parsing();
      test_odd_lines();
      test_read_errors();
      test_long_lines();
      test_output_stall();
      test_random_traffic();

      if (mismatches == 0) $display("PASSED: all results match");
      else $display("FAILED: results differ");
      $finish;
   end

endmodule

// ===== files.f =====
rtl/core/hrhs_pkg.sv
rtl/core/hrhs_req_if.sv
rtl/core/hrhs_rsp_if.sv
rtl/core/hrhs_scan.sv
rtl/core/http_response_header_scanner.sv
sim/http_response_header_scanner_tb.sv
